>>> rtl/dsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

    // operation kinds
    localparam logic [1:0] KIND_UPD64    = 2'd0;
    localparam logic [1:0] KIND_UPD16    = 2'd1;
    localparam logic [1:0] KIND_LZ_WRITE = 2'd2;
    localparam logic [1:0] KIND_COND     = 2'd3;

    // condition codes; 8..11 and 14 are undefined and test false
    localparam logic [3:0] COND_GE     = 4'h0;
    localparam logic [3:0] COND_L      = 4'h1;
    localparam logic [3:0] COND_G      = 4'h2;
    localparam logic [3:0] COND_LE     = 4'h3;
    localparam logic [3:0] COND_NZ     = 4'h4;
    localparam logic [3:0] COND_Z      = 4'h5;
    localparam logic [3:0] COND_NC     = 4'h6;
    localparam logic [3:0] COND_C      = 4'h7;
    localparam logic [3:0] COND_LNZ    = 4'hC;
    localparam logic [3:0] COND_LZ     = 4'hD;
    localparam logic [3:0] COND_ALWAYS = 4'hF;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned FLAGS_W = 7;

    // bit 0 carry up to bit 6 logic zero
    typedef struct packed {
        logic lzero;
        logic top2;
        logic above32;
        logic sign;
        logic zero;
        logic overflow;
        logic carry;
    } t_flags;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
        logic               carry_in;
        logic               overflow_in;
        logic               over_wide_in;
        logic               logic_zero_in;
        logic [3:0]         condition_code;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/dsf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dsf_item_if;
    import dsf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
    logic                      carry_in;
    logic                      overflow_in;
    logic                      over_wide_in;
    logic                      logic_zero_in;
    logic [3:0]                condition_code;

    modport source (
        output valid, kind, value, carry_in, overflow_in, over_wide_in,
               logic_zero_in, condition_code,
        input  ready
    );
    modport sink (
        input  valid, kind, value, carry_in, overflow_in, over_wide_in,
               logic_zero_in, condition_code,
        output ready
    );
endinterface

interface dsf_result_if;
    import dsf_pkg::*;

    logic               valid;
    logic               ready;
    logic [FLAGS_W-1:0] flags;
    logic               condition_met;

    modport source (output valid, flags, condition_met, input ready);
    modport sink   (input valid, flags, condition_met, output ready);
endinterface

`default_nettype wire

>>> rtl/dsp_status_flags_and_condition_check_top.sv
// Path: an item passes the input register, then the result register; o_result.valid
//   rises as the item moves from the input register into the result register.
// Throughput: one item per cycle while the output is not stalled; the flag register is
//   updated as an item enters the result register, so the next item sees it at once.
// Reset: synchronous, active low; clears all seven flags and both valid bits.
`timescale 1ns / 1ps
`default_nettype none

module dsp_status_flags_and_condition_check_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    dsf_item_if.sink       i_item,
    dsf_result_if.source   o_result
);
    import dsf_pkg::*;

    logic   r_in_valid;
    t_item  r_in;
    logic   r_out_valid;
    t_flags r_out_flags;
    logic   r_out_met;
    t_flags r_flags;

    t_flags n_flags;
    logic   n_met;
    logic   out_ready;
    logic   advance;

    assign out_ready    = ~r_out_valid | o_result.ready;
    assign advance      = r_in_valid & out_ready;
    assign i_item.ready = ~r_in_valid | advance;

    dsf_flag_calc u_calc (
        .i_item  (r_in),
        .i_flags (r_flags),
        .o_flags (n_flags),
        .o_met   (n_met)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.kind           <= i_item.kind;
            r_in.value          <= i_item.value;
            r_in.carry_in       <= i_item.carry_in;
            r_in.overflow_in    <= i_item.overflow_in;
            r_in.over_wide_in   <= i_item.over_wide_in;
            r_in.logic_zero_in  <= i_item.logic_zero_in;
            r_in.condition_code <= i_item.condition_code;
        end
        if (advance) begin
            r_out_flags <= n_flags;
            r_out_met   <= n_met;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.flags         = r_out_flags;
    assign o_result.condition_met = r_out_met;

    // a shown result always carries the flags as they stand now
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags == r_flags))
        else $error("result flags differ from flag register");

    // a condition check never alters the flags
    a_cond_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.kind == KIND_COND) |=> (r_flags == $past(r_flags)))
        else $error("condition check changed the flags");

    // a logic-zero write leaves the arithmetic flags alone
    a_lz_keeps_arith: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.kind == KIND_LZ_WRITE) |=> $stable(r_flags[5:0]))
        else $error("logic-zero write changed arithmetic flags");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid && r_flags == '0))
        else $error("reset did not clear control state");

endmodule

`default_nettype wire

>>> rtl/dsf_flag_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module dsf_flag_calc (
    input  dsf_pkg::t_item  i_item,
    input  dsf_pkg::t_flags i_flags,
    output dsf_pkg::t_flags o_flags,
    output logic            o_met
);
    import dsf_pkg::*;

    logic less;
    logic fits32;

    assign less = i_flags.overflow ^ i_flags.sign;
    // value fits in 32 bits when bits 63:31 all match the sign
    assign fits32 = (&i_item.value[63:31]) | ~(|i_item.value[63:31]);

    always_comb begin
        o_flags = i_flags;
        o_met   = 1'b0;
        case (i_item.kind)
            KIND_UPD64: begin
                o_flags.carry    = i_item.carry_in;
                o_flags.overflow = i_item.overflow_in;
                o_flags.zero     = ~(|i_item.value);
                o_flags.sign     = i_item.value[63];
                o_flags.above32  = ~fits32;
                o_flags.top2     = ~(i_item.value[31] ^ i_item.value[30]);
            end
            KIND_UPD16: begin
                o_flags.carry    = i_item.carry_in;
                o_flags.overflow = i_item.overflow_in;
                o_flags.zero     = ~(|i_item.value[15:0]);
                o_flags.sign     = i_item.value[15];
                o_flags.above32  = i_item.over_wide_in;
                o_flags.top2     = ~(i_item.value[15] ^ i_item.value[14]);
            end
            KIND_LZ_WRITE: begin
                o_flags.lzero = i_item.logic_zero_in;
            end
            default: begin
                case (i_item.condition_code)
                    COND_GE:     o_met = ~less;
                    COND_L:      o_met = less;
                    COND_G:      o_met = ~less & ~i_flags.zero;
                    COND_LE:     o_met = less | i_flags.zero;
                    COND_NZ:     o_met = ~i_flags.zero;
                    COND_Z:      o_met = i_flags.zero;
                    COND_NC:     o_met = ~i_flags.carry;
                    COND_C:      o_met = i_flags.carry;
                    COND_LNZ:    o_met = ~i_flags.lzero;
                    COND_LZ:     o_met = i_flags.lzero;
                    COND_ALWAYS: o_met = 1'b1;
                    default:     o_met = 1'b0;
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire
